FILE: design/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
`timescale 1ns / 1ps
package sfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int Q_DEPTH_DEF     = 4;
    localparam int ADDR_W          = 6;
    localparam int LEN_W           = 7;
    localparam int NUM_CNT         = 5;

    localparam logic [7:0]  SYNC0_BYTE = 8'hAA;
    localparam logic [7:0]  SYNC1_BYTE = 8'h55;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // event codes
    localparam logic [2:0] EV_PROG   = 3'd0;
    localparam logic [2:0] EV_GARB   = 3'd1;
    localparam logic [2:0] EV_BADLEN = 3'd2;
    localparam logic [2:0] EV_BADCRC = 3'd3;
    localparam logic [2:0] EV_OK     = 3'd4;

    // counter slots
    localparam int CNT_GARBAGE = 0;
    localparam int CNT_BADLEN  = 1;
    localparam int CNT_BADCRC  = 2;
    localparam int CNT_RESYNC  = 3;
    localparam int CNT_OK      = 4;

    typedef logic [NUM_CNT-1:0][31:0] cnt_vec_t;

    // one queued command: a status beat or a whole accepted frame
    typedef struct packed {
        logic [2:0]       ev;
        logic [7:0]       ftype;
        logic [7:0]       seq;
        logic [LEN_W-1:0] flen;
        cnt_vec_t         cnt;
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } pay_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: design/sfd_front.sv
// Front end: sync hunt, header parse, CRC check, payload write, command push.
`timescale 1ns / 1ps
module sfd_front #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  logic             in_valid,
    output logic             in_stall,
    input  sfd_pkg::q_stat_t q_stat,
    output logic             push,
    output sfd_pkg::cmd_t    push_cmd,
    output sfd_pkg::pay_wr_t pay_wr,
    input  logic             drain_done
);
    import sfd_pkg::*;

    typedef enum logic [7:0] {
        PH_SYNC0 = 8'b0000_0001,
        PH_SYNC1 = 8'b0000_0010,
        PH_LEN   = 8'b0000_0100,
        PH_TYPE  = 8'b0000_1000,
        PH_SEQ   = 8'b0001_0000,
        PH_PAY   = 8'b0010_0000,
        PH_CRCHI = 8'b0100_0000,
        PH_CRCLO = 8'b1000_0000
    } phase_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       seq_reg, seq_next;
    cnt_vec_t         cnt_reg, cnt_next;
    logic             mem_busy_reg, mem_busy_next;
    logic             accept;
    logic             pay_frame;
    logic [2:0]       ev;

    // the back end reads the payload store until a frame drain ends
    assign in_stall = q_stat.full || (phase_reg == PH_PAY && mem_busy_reg);
    assign accept   = in_valid && !in_stall;
    assign push     = accept;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        cnt_next    = cnt_reg;
        ev          = EV_PROG;
        pay_frame   = 1'b0;
        pay_wr.we   = 1'b0;
        pay_wr.addr = pos_reg[ADDR_W-1:0];
        pay_wr.data = rx_byte;
        push_cmd.ftype = 8'h00;
        push_cmd.seq   = 8'h00;
        push_cmd.flen  = '0;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == SYNC1_BYTE)
                    phase_next = PH_LEN;
                else if (rx_byte == SYNC0_BYTE)
                begin
                    cnt_next[CNT_GARBAGE] = cnt_reg[CNT_GARBAGE] + 32'd1;
                    ev = EV_GARB;
                end
                else
                begin
                    // the lone 0xAA is discarded too
                    cnt_next[CNT_GARBAGE] = cnt_reg[CNT_GARBAGE] + 32'd2;
                    phase_next = PH_SYNC0;
                    ev = EV_GARB;
                end
            end
            PH_LEN:
            begin
                if (rx_byte > MAX_LEN)
                begin
                    cnt_next[CNT_BADLEN] = cnt_reg[CNT_BADLEN] + 32'd1;
                    cnt_next[CNT_RESYNC] = cnt_reg[CNT_RESYNC] + 32'd1;
                    phase_next = PH_SYNC0;
                    ev = EV_BADLEN;
                end
                else
                begin
                    length_next = rx_byte[LEN_W-1:0];
                    pos_next    = '0;
                    crc_next    = crc_fold(CRC_INIT, rx_byte);
                    phase_next  = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next  = rx_byte;
                crc_next   = crc_fold(crc_reg, rx_byte);
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                seq_next   = rx_byte;
                crc_next   = crc_fold(crc_reg, rx_byte);
                phase_next = (length_reg == '0) ? PH_CRCHI : PH_PAY;
            end
            PH_PAY:
            begin
                pay_wr.we  = 1'b1;
                pos_next   = pos_reg + 1'b1;
                crc_next   = crc_fold(crc_reg, rx_byte);
                if (pos_next >= length_reg)
                    phase_next = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                crc_hi_next = rx_byte;
                phase_next  = PH_CRCLO;
            end
            PH_CRCLO:
            begin
                phase_next = PH_SYNC0;
                if ({crc_hi_reg, rx_byte} == crc_reg)
                begin
                    cnt_next[CNT_OK] = cnt_reg[CNT_OK] + 32'd1;
                    ev = EV_OK;
                    push_cmd.ftype = type_reg;
                    push_cmd.seq   = seq_reg;
                    push_cmd.flen  = length_reg;
                    pay_frame      = (length_reg != '0);
                end
                else
                begin
                    cnt_next[CNT_BADCRC] = cnt_reg[CNT_BADCRC] + 32'd1;
                    cnt_next[CNT_RESYNC] = cnt_reg[CNT_RESYNC] + 32'd1;
                    ev = EV_BADCRC;
                end
            end
            default:
            begin
                if (rx_byte == SYNC0_BYTE)
                    phase_next = PH_SYNC1;
                else
                begin
                    phase_next = PH_SYNC0;
                    cnt_next[CNT_GARBAGE] = cnt_reg[CNT_GARBAGE] + 32'd1;
                    ev = EV_GARB;
                end
            end
        endcase
        pay_wr.we    = pay_wr.we && accept;
        push_cmd.ev  = ev;
        push_cmd.cnt = cnt_next;
    end

    always_comb
    begin
        mem_busy_next = mem_busy_reg;
        if (drain_done)
            mem_busy_next = 1'b0;
        if (accept && pay_frame)
            mem_busy_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC0;
            length_reg   <= '0;
            pos_reg      <= '0;
            crc_reg      <= '0;
            crc_hi_reg   <= '0;
            type_reg     <= '0;
            seq_reg      <= '0;
            cnt_reg      <= '0;
            mem_busy_reg <= 1'b0;
        end
        else
        begin
            mem_busy_reg <= mem_busy_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                crc_hi_reg <= crc_hi_next;
                type_reg   <= type_next;
                seq_reg    <= seq_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pay_wr.we |-> !mem_busy_reg)
        else $error("payload write during drain");
    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        drain_done |-> mem_busy_reg)
        else $error("drain done without pending frame");
    a_single_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pay_frame) |-> !mem_busy_reg)
        else $error("second payload frame while store busy");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule

FILE: design/sfd_queue.sv
// Short command queue between front and back ends.
`timescale 1ns / 1ps
module sfd_queue #(
    parameter int DEPTH = sfd_pkg::Q_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfd_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output sfd_pkg::cmd_t    pop_cmd,
    output sfd_pkg::q_stat_t q_stat
);
    import sfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign q_stat.full  = (fill_reg == FULL_CNT);
    assign q_stat.empty = (fill_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

FILE: design/sfd_back.sv
// Back end: payload store, frame drain and output register.
`timescale 1ns / 1ps
module sfd_back #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sfd_pkg::q_stat_t          q_stat,
    output logic                      pop,
    input  sfd_pkg::cmd_t             pop_cmd,
    input  sfd_pkg::pay_wr_t          pay_wr,
    output logic                      drain_done,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                event_res,
    output logic [7:0]                frame_type,
    output logic [7:0]                seq_num,
    output logic [sfd_pkg::LEN_W-1:0] frame_len,
    output logic [7:0]                payload_byte,
    output logic [sfd_pkg::ADDR_W-1:0] payload_index,
    output logic                      last,
    output logic [31:0]               garbage_count,
    output logic [31:0]               bad_length_count,
    output logic [31:0]               bad_crc_count,
    output logic [31:0]               resync_count,
    output logic [31:0]               ok_count
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_PRIME = 3'b010,
        B_DRAIN = 3'b100
    } bstate_t;

    logic [7:0]        mem [MAX_PAYLOAD];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] rd_addr;

    bstate_t           state_reg, state_next;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg;
    logic              out_free;
    logic              load_status, load_pay, take_frame;
    logic              last_pay;

    cmd_t              ocmd_reg;
    logic [7:0]        obyte_reg;
    logic [ADDR_W-1:0] oidx_reg;
    logic              olast_reg;

    always_ff @(posedge clk)
    begin
        if (pay_wr.we)
            mem[pay_wr.addr] <= pay_wr.data;
        rdata_reg <= mem[rd_addr];
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign last_pay = ({1'b0, idx_reg} + 1'b1) == cmd_reg.flen;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;
        load_status = 1'b0;
        load_pay    = 1'b0;
        take_frame  = 1'b0;
        drain_done  = 1'b0;
        rd_addr     = idx_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop = 1'b1;
                    if (pop_cmd.ev == EV_OK && pop_cmd.flen != '0)
                    begin
                        take_frame = 1'b1;
                        state_next = B_PRIME;
                    end
                    else
                        load_status = 1'b1;
                end
            end
            B_PRIME:
            begin
                rd_addr    = '0;
                idx_next   = '0;
                state_next = B_DRAIN;
            end
            B_DRAIN:
            begin
                if (out_free)
                begin
                    // rdata holds entry idx; fetch the following one
                    load_pay = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (last_pay)
                    begin
                        drain_done = 1'b1;
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (load_status || load_pay)
                out_valid_reg <= 1'b1;
            else if (out_free)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_frame)
            cmd_reg <= pop_cmd;
        if (load_status)
        begin
            ocmd_reg  <= pop_cmd;
            obyte_reg <= 8'h00;
            oidx_reg  <= '0;
            olast_reg <= 1'b1;
        end
        else if (load_pay)
        begin
            ocmd_reg  <= cmd_reg;
            obyte_reg <= rdata_reg;
            oidx_reg  <= idx_reg;
            olast_reg <= last_pay;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = ocmd_reg.ev;
    assign frame_type       = ocmd_reg.ftype;
    assign seq_num          = ocmd_reg.seq;
    assign frame_len        = ocmd_reg.flen;
    assign payload_byte     = obyte_reg;
    assign payload_index    = oidx_reg;
    assign last             = olast_reg;
    assign garbage_count    = ocmd_reg.cnt[CNT_GARBAGE];
    assign bad_length_count = ocmd_reg.cnt[CNT_BADLEN];
    assign bad_crc_count    = ocmd_reg.cnt[CNT_BADCRC];
    assign resync_count     = ocmd_reg.cnt[CNT_RESYNC];
    assign ok_count         = ocmd_reg.cnt[CNT_OK];

endmodule

FILE: design/serial_frame_deframer_crc16.sv
// Top level of the serial frame deframer with CRC-16 check.
//
// Input channel: one received byte per beat (rx_byte, in_valid, in_stall).
// Output channel: one result beat per status or payload byte (out_valid,
// out_stall and the result fields).
// The front end parses one byte per cycle unless in_stall is high: sync
// hunt, LEN, TYPE, SEQ, payload and CRC, with the CRC folded a byte per
// cycle. Every byte pushes one command into a four-entry queue; the back
// end turns each command into one beat, or drains an accepted frame from
// the payload store at one beat per cycle while out_stall is low, after a
// priming state for the registered read. Input rate is one byte per cycle;
// the front stalls when the queue is full, and in the payload phase while
// the previous frame is still being drained from the single payload store.
// Reset clears the parser, counters, queue and output valid flag; the
// payload store needs no clearing. When the receiver stalls, the output
// beat holds and the queue absorbs up to four more bytes before in_stall.
`timescale 1ns / 1ps
module serial_frame_deframer_crc16 #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF,
    parameter int Q_DEPTH     = sfd_pkg::Q_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 rx_byte,
    input  logic                       in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 event_res,
    output logic [7:0]                 frame_type,
    output logic [7:0]                 seq_num,
    output logic [sfd_pkg::LEN_W-1:0]  frame_len,
    output logic [7:0]                 payload_byte,
    output logic [sfd_pkg::ADDR_W-1:0] payload_index,
    output logic                       last,
    output logic [31:0]                garbage_count,
    output logic [31:0]                bad_length_count,
    output logic [31:0]                bad_crc_count,
    output logic [31:0]                resync_count,
    output logic [31:0]                ok_count
);
    import sfd_pkg::*;

    q_stat_t q_stat;
    logic    push, pop, drain_done;
    cmd_t    push_cmd, pop_cmd;
    pay_wr_t pay_wr;

    sfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .q_stat     (q_stat),
        .push       (push),
        .push_cmd   (push_cmd),
        .pay_wr     (pay_wr),
        .drain_done (drain_done)
    );

    sfd_queue #(.DEPTH(Q_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    sfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_stat           (q_stat),
        .pop              (pop),
        .pop_cmd          (pop_cmd),
        .pay_wr           (pay_wr),
        .drain_done       (drain_done),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_res        (event_res),
        .frame_type       (frame_type),
        .seq_num          (seq_num),
        .frame_len        (frame_len),
        .payload_byte     (payload_byte),
        .payload_index    (payload_index),
        .last             (last),
        .garbage_count    (garbage_count),
        .bad_length_count (bad_length_count),
        .bad_crc_count    (bad_crc_count),
        .resync_count     (resync_count),
        .ok_count         (ok_count)
    );

endmodule

FILE: verif/serial_frame_deframer_crc16_tb.sv
// Self-checking testbench for the serial frame deframer: random byte streams against a predictor.
`timescale 1ns / 1ps
module serial_frame_deframer_crc16_tb;
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        HUNT_AA, HUNT_55, GET_LEN, GET_TYPE, GET_SEQ, GET_PAYLOAD, GET_CRC_HI, GET_CRC_LO
    } parse_phase_e;

    typedef struct packed {
        logic [2:0]        ev;
        logic [7:0]        ftype;
        logic [7:0]        fseq;
        logic [LEN_W-1:0]  flen;
        logic [7:0]        pbyte;
        logic [ADDR_W-1:0] pidx;
        logic              last_flag;
        logic [31:0]       garbage;
        logic [31:0]       badlen;
        logic [31:0]       badcrc;
        logic [31:0]       resync;
        logic [31:0]       good;
    } result_t;

    class frame_scoreboard;
        parse_phase_e     phase;
        logic [LEN_W-1:0] flen;
        logic [LEN_W-1:0] pos;
        logic [15:0]      crc;
        logic [7:0]       crc_hi;
        logic [7:0]       ftype;
        logic [7:0]       fseq;
        logic [7:0]       pay_mem [64];
        logic [31:0]      garbage, badlen, badcrc, resync, good;
        result_t          expected_q [$];
        int               failures;
        int               beats_seen;
        int               payload_beats;
        int               longest;

        function new();
            phase = HUNT_AA;
            flen = '0;
            pos = '0;
            crc = '0;
            crc_hi = '0;
            ftype = '0;
            fseq = '0;
            garbage = '0;
            badlen = '0;
            badcrc = '0;
            resync = '0;
            good = '0;
            failures = 0;
            beats_seen = 0;
            payload_beats = 0;
            longest = -1;
        endfunction

        // CRC-16/CCITT-FALSE, one byte MSB first
        static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
            int k;
            c = c ^ {b, 8'h00};
            for (k = 0; k < 8; k++)
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void add(logic [2:0] ev, logic [7:0] ty, logic [7:0] sq,
                          logic [LEN_W-1:0] ln, logic [7:0] pb,
                          logic [ADDR_W-1:0] pi, logic lst);
            result_t r;
            r = '{ev, ty, sq, ln, pb, pi, lst, garbage, badlen, badcrc, resync, good};
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [2:0] ev;
            int i;
            ev = EV_PROG;
            case (phase)
                HUNT_55:
                    if (b == SYNC1_BYTE) begin
                        phase = GET_LEN;
                    end else if (b == SYNC0_BYTE) begin
                        garbage += 32'd1;
                        ev = EV_GARB;
                    end else begin
                        garbage += 32'd2;
                        phase = HUNT_AA;
                        ev = EV_GARB;
                    end
                GET_LEN:
                    if (b > MAX_PAYLOAD_DEF) begin
                        badlen += 32'd1;
                        resync += 32'd1;
                        phase = HUNT_AA;
                        ev = EV_BADLEN;
                    end else begin
                        flen = b[LEN_W-1:0];
                        pos = '0;
                        crc = crc_fold(CRC_INIT, b);
                        phase = GET_TYPE;
                    end
                GET_TYPE:
                begin
                    ftype = b;
                    crc = crc_fold(crc, b);
                    phase = GET_SEQ;
                end
                GET_SEQ:
                begin
                    fseq = b;
                    crc = crc_fold(crc, b);
                    phase = (flen == 0) ? GET_CRC_HI : GET_PAYLOAD;
                end
                GET_PAYLOAD:
                begin
                    pay_mem[pos[ADDR_W-1:0]] = b;
                    pos = pos + 1'b1;
                    crc = crc_fold(crc, b);
                    if (pos >= flen)
                        phase = GET_CRC_HI;
                end
                GET_CRC_HI:
                begin
                    crc_hi = b;
                    phase = GET_CRC_LO;
                end
                GET_CRC_LO:
                begin
                    phase = HUNT_AA;
                    if ({crc_hi, b} == crc) begin
                        good += 32'd1;
                        if (int'(flen) > longest)
                            longest = flen;
                        if (flen == 0) begin
                            add(EV_OK, ftype, fseq, '0, '0, '0, 1'b1);
                        end else begin
                            for (i = 0; i < flen; i++)
                                add(EV_OK, ftype, fseq, flen, pay_mem[i[ADDR_W-1:0]],
                                    i[ADDR_W-1:0], i + 1 == flen);
                            payload_beats += flen;
                        end
                        return;
                    end
                    badcrc += 32'd1;
                    resync += 32'd1;
                    ev = EV_BADCRC;
                end
                default:
                    if (b == SYNC0_BYTE) begin
                        phase = HUNT_55;
                    end else begin
                        garbage += 32'd1;
                        ev = EV_GARB;
                    end
            endcase
            add(ev, '0, '0, '0, '0, '0, 1'b1);
        endfunction

        function string show(result_t r);
            return $sformatf({"ev=%0d type=%02h seq=%02h len=%0d byte=%02h idx=%0d",
                              " last=%0b cnt=%0d/%0d/%0d/%0d/%0d"},
                             r.ev, r.ftype, r.fseq, r.flen, r.pbyte, r.pidx, r.last_flag,
                             r.garbage, r.badlen, r.badcrc, r.resync, r.good);
        endfunction

        function void check_result(result_t got);
            result_t want;
            string   diff;
            beats_seen++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: beat %0d arrived with nothing expected: %s",
                             beats_seen, show(got));
                return;
            end
            want = expected_q.pop_front();
            diff = "";
            if (got.ev !== want.ev)               diff = {diff, " event_res"};
            if (got.ftype !== want.ftype)         diff = {diff, " frame_type"};
            if (got.fseq !== want.fseq)           diff = {diff, " seq_num"};
            if (got.flen !== want.flen)           diff = {diff, " frame_len"};
            if (got.pbyte !== want.pbyte)         diff = {diff, " payload_byte"};
            if (got.pidx !== want.pidx)           diff = {diff, " payload_index"};
            if (got.last_flag !== want.last_flag) diff = {diff, " last"};
            if (got.garbage !== want.garbage)     diff = {diff, " garbage_count"};
            if (got.badlen !== want.badlen)       diff = {diff, " bad_length_count"};
            if (got.badcrc !== want.badcrc)       diff = {diff, " bad_crc_count"};
            if (got.resync !== want.resync)       diff = {diff, " resync_count"};
            if (got.good !== want.good)           diff = {diff, " ok_count"};
            if (diff != "") begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: beat %0d differs in%s\n  expected %s\n  actual   %s",
                             beats_seen, diff, show(want), show(got));
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic [7:0]           rx_byte;
    logic                 in_valid;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           event_res;
    logic [7:0]           frame_type;
    logic [7:0]           seq_num;
    logic [LEN_W-1:0]     frame_len;
    logic [7:0]           payload_byte;
    logic [ADDR_W-1:0]    payload_index;
    logic                 last;
    logic [31:0]          garbage_count;
    logic [31:0]          bad_length_count;
    logic [31:0]          bad_crc_count;
    logic [31:0]          resync_count;
    logic [31:0]          ok_count;

    frame_scoreboard sb = new();
    int bytes_sent = 0;
    bit calm = 1'b0;

    serial_frame_deframer_crc16 u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_byte          (rx_byte),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_res        (event_res),
        .frame_type       (frame_type),
        .seq_num          (seq_num),
        .frame_len        (frame_len),
        .payload_byte     (payload_byte),
        .payload_index    (payload_index),
        .last             (last),
        .garbage_count    (garbage_count),
        .bad_length_count (bad_length_count),
        .bad_crc_count    (bad_crc_count),
        .resync_count     (resync_count),
        .ok_count         (ok_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // in_valid stays high across back-to-back beats; it only drops for an idle gap
    task automatic send_byte(input logic [7:0] b);
        int pct;
        pct = calm ? 0 : 22;
        if ($urandom_range(99) < pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        calm = (bytes_sent >= 180 && bytes_sent < 280);
    endtask

    // sync, LEN, TYPE, SEQ, payload, CRC; stops after LEN when the length is oversized
    task automatic send_frame(input int len, input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  b;
        send_byte(SYNC0_BYTE);
        send_byte(SYNC1_BYTE);
        send_byte(len[7:0]);
        if (len > MAX_PAYLOAD_DEF)
            return;
        crc = frame_scoreboard::crc_fold(CRC_INIT, len[7:0]);
        repeat (len + 2) begin
            b = 8'($urandom_range(255));
            send_byte(b);
            crc = frame_scoreboard::crc_fold(crc, b);
        end
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    initial
    begin
        int frame_no;
        int roll;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: plain garbage, repeated sync byte, broken sync, length just over
        // the limit, empty good frame, one-byte frame with a bad checksum
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC0_BYTE);
        send_byte(SYNC0_BYTE);
        send_byte(8'h12);
        send_byte(SYNC0_BYTE);
        send_byte(SYNC1_BYTE);
        send_byte(8'(MAX_PAYLOAD_DEF + 1));
        send_frame(0, 1'b0);
        send_frame(1, 1'b1);

        frame_no = 0;
        while (bytes_sent < 410) begin
            roll = $urandom_range(99);
            if (frame_no == 0)
                send_frame(MAX_PAYLOAD_DEF, 1'b0);
            else if (frame_no == 1)
                send_frame(255, 1'b0);
            else if (roll < 70)
                send_frame(($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD_DEF)
                                                   : $urandom_range(6),
                           $urandom_range(99) < 15);
            else if (roll < 80)
                send_frame($urandom_range(255, MAX_PAYLOAD_DEF + 1), 1'b0);
            else if (roll < 90) begin
                send_byte(SYNC0_BYTE);
                send_byte(8'($urandom_range(255)));
            end else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            frame_no++;
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run: %0d bytes in, %0d result beats; %0d good frames (longest %0d bytes)",
                 bytes_sent, sb.beats_seen, sb.good, sb.longest);
        $display("Payload beats %0d; rejects: %0d garbage, %0d oversized, %0d bad crc, %0d resyncs",
                 sb.payload_beats, sb.garbage, sb.badlen, sb.badcrc, sb.resync);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, one long hold-off so the queue fills and the input stalls
    initial
    begin
        int cyc;
        cyc = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc >= 150 && cyc < 450)
                out_stall <= 1'b1;
            else
                out_stall <= !calm && ($urandom_range(99) < 22);
        end
    end

    always @(posedge clk)
    begin : take_result
        result_t beat;
        if (rst_n && out_valid && !out_stall) begin
            beat = '{event_res, frame_type, seq_num, frame_len, payload_byte, payload_index,
                     last, garbage_count, bad_length_count, bad_crc_count, resync_count,
                     ok_count};
            sb.check_result(beat);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 2000) begin
                $display("ERROR: no beat moved for %0d cycles, %0d results still due",
                         quiet_cycles, sb.expected_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
design/sfd_pkg.sv
design/sfd_front.sv
design/sfd_queue.sv
design/sfd_back.sv
design/serial_frame_deframer_crc16.sv
verif/serial_frame_deframer_crc16_tb.sv
